>>> design/psag_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psag_pkg;

  // largest grid size along any axis, larger size registers saturate here
  localparam int unsigned DIM_MAX = 1024;

  localparam int unsigned SizeW    = 11;
  localparam int unsigned PosW     = 10;
  localparam int unsigned RangeW   = 12;
  localparam int unsigned AddrW    = 30;
  localparam int unsigned StrideW  = 21;
  localparam int unsigned CntW     = 11;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned PdataW   = 32;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef logic [SizeW-1:0] dim_t;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_e;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_POS,
    ST_MUL_IN,
    ST_MUL_OUT,
    ST_SUM,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_POS,
    MUL_IN,
    MUL_OUT
  } mul_sel_e;

  typedef struct packed {
    logic     capture;
    logic     prep;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     finish;
    logic     advance;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic out_full;
  } dp_status_t;

  // inner axis follows the plane axis, outer axis follows the inner one
  function automatic logic [1:0] next_axis(logic [1:0] axis);
    logic [1:0] res;
    case (axis)
      AXIS_X:  res = AXIS_Y;
      AXIS_Y:  res = AXIS_Z;
      default: res = AXIS_X;
    endcase
    return res;
  endfunction

  function automatic dim_t eff_size(dim_t raw);
    return (raw > dim_t'(DIM_MAX)) ? dim_t'(DIM_MAX) : raw;
  endfunction

endpackage

`default_nettype wire

>>> design/psag_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module psag_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [psag_pkg::PaddrW-1:0]        paddr,
  input  wire logic [psag_pkg::PdataW-1:0]        pwdata,
  output logic      [psag_pkg::PdataW-1:0]        prdata,
  output logic                                    pready,
  output logic      [2:0][psag_pkg::SizeW-1:0]    sizes_o
);

  psag_pkg::dim_t size_x_q, size_y_q, size_z_q;
  logic           wr_en;
  psag_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = psag_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= psag_pkg::dim_t'(1);
      size_y_q <= psag_pkg::dim_t'(1);
      size_z_q <= psag_pkg::dim_t'(1);
    end else if (wr_en) begin
      case (reg_idx)
        psag_pkg::REG_SIZE_X: size_x_q <= pwdata[psag_pkg::SizeW-1:0];
        psag_pkg::REG_SIZE_Y: size_y_q <= pwdata[psag_pkg::SizeW-1:0];
        psag_pkg::REG_SIZE_Z: size_z_q <= pwdata[psag_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      psag_pkg::REG_SIZE_X: prdata = psag_pkg::PdataW'(size_x_q);
      psag_pkg::REG_SIZE_Y: prdata = psag_pkg::PdataW'(size_y_q);
      psag_pkg::REG_SIZE_Z: prdata = psag_pkg::PdataW'(size_z_q);
      default:              prdata = '0;
    endcase
  end

  // sizes as the datapath sees them, saturated at the grid limit
  assign sizes_o[0] = psag_pkg::eff_size(size_x_q);
  assign sizes_o[1] = psag_pkg::eff_size(size_y_q);
  assign sizes_o[2] = psag_pkg::eff_size(size_z_q);

endmodule

`default_nettype wire

>>> design/psag_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module psag_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 opcode_i,
  input  wire psag_pkg::dp_status_t status_i,
  output psag_pkg::dp_cmd_t         cmd_o,
  output logic                      in_stall_o
);

  psag_pkg::state_e state_q, state_d;
  logic             accept;

  assign in_stall_o = (state_q != psag_pkg::ST_IDLE) || status_i.out_full;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psag_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      psag_pkg::ST_IDLE: begin
        if (accept && (opcode_i == psag_pkg::OP_START)) state_d = psag_pkg::ST_PREP;
      end
      psag_pkg::ST_PREP: begin
        state_d = status_i.empty ? psag_pkg::ST_DONE : psag_pkg::ST_MUL_POS;
      end
      psag_pkg::ST_MUL_POS: state_d = psag_pkg::ST_MUL_IN;
      psag_pkg::ST_MUL_IN:  state_d = psag_pkg::ST_MUL_OUT;
      psag_pkg::ST_MUL_OUT: state_d = psag_pkg::ST_SUM;
      psag_pkg::ST_SUM:     state_d = psag_pkg::ST_DONE;
      psag_pkg::ST_DONE: begin
        if (!status_i.out_full) state_d = psag_pkg::ST_IDLE;
      end
      default: state_d = psag_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = psag_pkg::MUL_POS;
    case (state_q)
      psag_pkg::ST_IDLE: begin
        cmd_o.capture = accept && (opcode_i == psag_pkg::OP_START);
        cmd_o.advance = accept && (opcode_i == psag_pkg::OP_ADVANCE);
      end
      psag_pkg::ST_PREP: cmd_o.prep = 1'b1;
      psag_pkg::ST_MUL_POS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      psag_pkg::ST_MUL_IN: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = psag_pkg::MUL_IN;
        cmd_o.acc_add = 1'b1;
      end
      psag_pkg::ST_MUL_OUT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = psag_pkg::MUL_OUT;
        cmd_o.acc_add = 1'b1;
      end
      psag_pkg::ST_SUM: cmd_o.acc_add = 1'b1;
      psag_pkg::ST_DONE: cmd_o.finish = !status_i.out_full;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> design/psag_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module psag_dp (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire psag_pkg::dp_cmd_t                      cmd_i,
  output psag_pkg::dp_status_t                        status_o,
  input  wire logic [2:0][psag_pkg::SizeW-1:0]        sizes_i,
  input  wire logic [1:0]                             plane_axis_i,
  input  wire logic [psag_pkg::PosW-1:0]              plane_pos_i,
  input  wire logic [2:0][psag_pkg::RangeW-1:0]       lo_i,
  input  wire logic [2:0][psag_pkg::RangeW-1:0]       hi_i,
  input  wire logic                                   out_stall_i,
  output logic                                        out_valid_o,
  output logic      [psag_pkg::AddrW-1:0]             address_o,
  output logic                                        addr_valid_o,
  output logic                                        last_o,
  output logic                                        empty_res_o,
  output logic      [psag_pkg::CntW-1:0]              inner_count_o,
  output logic      [psag_pkg::CntW-1:0]              outer_count_o
);

  localparam int unsigned AddrW   = psag_pkg::AddrW;
  localparam int unsigned StrideW = psag_pkg::StrideW;
  localparam int unsigned CntW    = psag_pkg::CntW;
  localparam int unsigned PosW    = psag_pkg::PosW;
  localparam int unsigned RangeW  = psag_pkg::RangeW;
  localparam int unsigned SizeW   = psag_pkg::SizeW;

  // captured start item, ranges already clamped
  logic [1:0]                    plane_q;
  logic [PosW-1:0]               pos_q;
  logic [2:0][SizeW-1:0]         lo_q;
  logic [2:0][RangeW-1:0]        hi_q;
  logic [2:0][SizeW-1:0]         lo_clamp;
  logic [2:0][RangeW-1:0]        hi_clamp;
  logic [2:0][RangeW-1:0]        szm1;

  // setup results
  logic                          empty_q;
  logic [1:0]                    ia_q, oa_q;
  logic [CntW-1:0]               in_span_p_q, out_span_p_q;
  logic [PosW-1:0]               lo_in_q, lo_out_q;
  logic [StrideW-1:0]            stride2_q;
  logic [2:0]                    axis_empty;
  logic [1:0]                    ia, oa;
  logic [SizeW-1:0]              plane_sz;
  logic                          prep_empty;
  logic [RangeW-1:0]             in_span_w, out_span_w;
  logic [2*SizeW-1:0]            area;

  // shared multiplier and accumulator
  logic [PosW-1:0]               mul_a;
  logic [1:0]                    mul_axis;
  logic [StrideW-1:0]            mul_b;
  logic [PosW+StrideW-1:0]       mul_p;
  logic [AddrW-1:0]              prod_q, acc_q;

  // walk state
  logic                          active_q;
  logic [PosW-1:0]               inner_idx_q, outer_idx_q;
  logic [CntW-1:0]               inner_span_q, outer_span_q;
  logic [StrideW-1:0]            inner_stride_q, outer_stride_q;
  logic [AddrW-1:0]              cur_addr_q, row_addr_q;
  logic                          inner_end, outer_end, fin;

  logic                          out_valid_q, out_load;

  function automatic logic [StrideW-1:0] stride_of(logic [1:0] axis,
                                                   logic [SizeW-1:0] sx,
                                                   logic [StrideW-1:0] s2);
    logic [StrideW-1:0] res;
    case (axis)
      psag_pkg::AXIS_Y: res = StrideW'(sx);
      psag_pkg::AXIS_Z: res = s2;
      default:          res = StrideW'(1);
    endcase
    return res;
  endfunction

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      szm1[a]     = {1'b0, sizes_i[a]} - RangeW'(1);
      hi_clamp[a] = ($signed(hi_i[a]) > $signed(szm1[a])) ? szm1[a] : hi_i[a];
      lo_clamp[a] = lo_i[a][RangeW-1] ? '0 : lo_i[a][SizeW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      plane_q <= plane_axis_i;
      pos_q   <= plane_pos_i;
      lo_q    <= lo_clamp;
      hi_q    <= hi_clamp;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      axis_empty[a] = $signed({1'b0, lo_q[a]}) > $signed(hi_q[a]);
    end
    ia = psag_pkg::next_axis(plane_q);
    oa = psag_pkg::next_axis(ia);
    case (plane_q)
      psag_pkg::AXIS_X: plane_sz = sizes_i[0];
      psag_pkg::AXIS_Y: plane_sz = sizes_i[1];
      psag_pkg::AXIS_Z: plane_sz = sizes_i[2];
      default:          plane_sz = '0;
    endcase
    // plane axis code 3 has size zero here, so it always comes out empty
    prep_empty = ({1'b0, pos_q} >= plane_sz) || axis_empty[ia] || axis_empty[oa];
    in_span_w  = hi_q[ia] - {1'b0, lo_q[ia]} + RangeW'(1);
    out_span_w = hi_q[oa] - {1'b0, lo_q[oa]} + RangeW'(1);
  end

  assign area = sizes_i[0] * sizes_i[1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      empty_q      <= prep_empty;
      ia_q         <= ia;
      oa_q         <= oa;
      in_span_p_q  <= in_span_w[CntW-1:0];
      out_span_p_q <= out_span_w[CntW-1:0];
      lo_in_q      <= lo_q[ia][PosW-1:0];
      lo_out_q     <= lo_q[oa][PosW-1:0];
      stride2_q    <= area[StrideW-1:0];
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      psag_pkg::MUL_POS: begin
        mul_a    = pos_q;
        mul_axis = plane_q;
      end
      psag_pkg::MUL_IN: begin
        mul_a    = lo_in_q;
        mul_axis = ia_q;
      end
      psag_pkg::MUL_OUT: begin
        mul_a    = lo_out_q;
        mul_axis = oa_q;
      end
      default: begin
        mul_a    = '0;
        mul_axis = psag_pkg::AXIS_X;
      end
    endcase
    mul_b = stride_of(mul_axis, sizes_i[0], stride2_q);
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= mul_p[AddrW-1:0];
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
  end

  assign inner_end = ({1'b0, inner_idx_q} + CntW'(1)) >= inner_span_q;
  assign outer_end = ({1'b0, outer_idx_q} + CntW'(1)) >= outer_span_q;
  assign fin       = inner_end && outer_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q       <= 1'b0;
      inner_idx_q    <= '0;
      outer_idx_q    <= '0;
      inner_span_q   <= '0;
      outer_span_q   <= '0;
      inner_stride_q <= '0;
      outer_stride_q <= '0;
      cur_addr_q     <= '0;
      row_addr_q     <= '0;
    end else if (cmd_i.finish) begin
      inner_idx_q <= '0;
      outer_idx_q <= '0;
      if (empty_q) begin
        active_q       <= 1'b0;
        inner_span_q   <= '0;
        outer_span_q   <= '0;
        inner_stride_q <= '0;
        outer_stride_q <= '0;
        cur_addr_q     <= '0;
        row_addr_q     <= '0;
      end else begin
        active_q       <= 1'b1;
        inner_span_q   <= in_span_p_q;
        outer_span_q   <= out_span_p_q;
        inner_stride_q <= stride_of(ia_q, sizes_i[0], stride2_q);
        outer_stride_q <= stride_of(oa_q, sizes_i[0], stride2_q);
        cur_addr_q     <= acc_q;
        row_addr_q     <= acc_q;
      end
    end else if (cmd_i.advance && active_q) begin
      if (fin) begin
        active_q <= 1'b0;
      end else if (!inner_end) begin
        inner_idx_q <= inner_idx_q + PosW'(1);
        cur_addr_q  <= cur_addr_q + AddrW'(inner_stride_q);
      end else begin
        inner_idx_q <= '0;
        outer_idx_q <= outer_idx_q + PosW'(1);
        row_addr_q  <= row_addr_q + AddrW'(outer_stride_q);
        cur_addr_q  <= row_addr_q + AddrW'(outer_stride_q);
      end
    end
  end

  assign out_load = cmd_i.finish || cmd_i.advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      address_o     <= '0;
      addr_valid_o  <= 1'b0;
      last_o        <= 1'b0;
      empty_res_o   <= empty_q;
      inner_count_o <= empty_q ? '0 : in_span_p_q;
      outer_count_o <= empty_q ? '0 : out_span_p_q;
    end else if (cmd_i.advance) begin
      address_o     <= active_q ? cur_addr_q : '0;
      addr_valid_o  <= active_q;
      last_o        <= active_q && fin;
      empty_res_o   <= 1'b0;
      inner_count_o <= inner_span_q;
      outer_count_o <= outer_span_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.empty    = prep_empty;
  assign status_o.out_full = out_valid_q && out_stall_i;

endmodule

`default_nettype wire

>>> design/plane_slice_address_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Address generator for one axis-aligned slice of a 3D raster of size_x by
// size_y by size_z points, giving the linear address i + size_x*j +
// size_x*size_y*k of each slice element. A start item (opcode 0) names the
// axis normal to the slice, the slice position and a lo..hi range per axis;
// in-plane ranges are clamped to 0..size-1, and an empty range, a position
// past the end of its axis or plane axis 3 gives a result with empty_res set.
// The inner axis is (plane+1) mod 3 and the outer axis (plane+2) mod 3.
// Each advance item (opcode 1) returns one address, with last set on the
// final one; an advance while no slice is open returns addr_valid low.
// Every item gives exactly one result. Advance items are taken one per
// cycle while no result is held. A start item holds the input while a
// setup step, then three passes through the single shared 10 x 21 bit
// multiplier and a final add build the first address; an empty slice skips
// the passes. Sizes above 1024 saturate at 1024; addresses wrap at 2^30.
// Size registers sit at byte addresses 0, 4 and 8 and reset to 1; write
// them only while the block is idle.
module plane_slice_address_generator_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [psag_pkg::PaddrW-1:0]       paddr,
  input  wire logic [psag_pkg::PdataW-1:0]       pwdata,
  output logic      [psag_pkg::PdataW-1:0]       prdata,
  output logic                                   pready,

  // item input
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              opcode_i,
  input  wire logic [1:0]                        plane_axis_i,
  input  wire logic [psag_pkg::PosW-1:0]         plane_pos_i,
  input  wire logic [psag_pkg::RangeW-1:0]       lo_axis0_i,
  input  wire logic [psag_pkg::RangeW-1:0]       hi_axis0_i,
  input  wire logic [psag_pkg::RangeW-1:0]       lo_axis1_i,
  input  wire logic [psag_pkg::RangeW-1:0]       hi_axis1_i,
  input  wire logic [psag_pkg::RangeW-1:0]       lo_axis2_i,
  input  wire logic [psag_pkg::RangeW-1:0]       hi_axis2_i,

  // result output
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [psag_pkg::AddrW-1:0]        address_o,
  output logic                                   addr_valid_o,
  output logic                                   last_o,
  output logic                                   empty_res_o,
  output logic      [psag_pkg::CntW-1:0]         inner_count_o,
  output logic      [psag_pkg::CntW-1:0]         outer_count_o
);

  logic [2:0][psag_pkg::SizeW-1:0]  sizes;
  logic [2:0][psag_pkg::RangeW-1:0] lo_all, hi_all;
  psag_pkg::dp_cmd_t                cmd;
  psag_pkg::dp_status_t             status;

  assign lo_all = {lo_axis2_i, lo_axis1_i, lo_axis0_i};
  assign hi_all = {hi_axis2_i, hi_axis1_i, hi_axis0_i};

  // size registers, read back raw, handed on saturated
  psag_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sizes_o (sizes)
  );

  // sequencer for the start setup and the input handshake
  psag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // clamping, shared multiplier, walk counters and output register
  psag_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .sizes_i       (sizes),
    .plane_axis_i  (plane_axis_i),
    .plane_pos_i   (plane_pos_i),
    .lo_i          (lo_all),
    .hi_i          (hi_all),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .address_o     (address_o),
    .addr_valid_o  (addr_valid_o),
    .last_o        (last_o),
    .empty_res_o   (empty_res_o),
    .inner_count_o (inner_count_o),
    .outer_count_o (outer_count_o)
  );

  // a held result must keep new items out
  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("item taken while a result was held");

  // last only ever marks a real address
  a_last_is_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> addr_valid_o && !empty_res_o)
    else $error("last without a valid address");

  // an empty slice reports zero counts and no address
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |->
      !addr_valid_o && (inner_count_o == '0) && (outer_count_o == '0))
    else $error("empty result carries counts or an address");

endmodule

`default_nettype wire
